FILE: hw/rtl/md5_pkg.sv
// Shared types, codes and constant tables of the MD5 digest block.
package md5_pkg;

	// Datapath operation codes, one per microprogram step.
	localparam logic [3:0] OP_ABSORB = 4'd0;
	localparam logic [3:0] OP_PAD    = 4'd1;
	localparam logic [3:0] OP_ZHI    = 4'd2;
	localparam logic [3:0] OP_ZLO    = 4'd3;
	localparam logic [3:0] OP_LEN0   = 4'd4;
	localparam logic [3:0] OP_LEN1   = 4'd5;
	localparam logic [3:0] OP_CINIT  = 4'd6;
	localparam logic [3:0] OP_ROUND  = 4'd7;
	localparam logic [3:0] OP_CADD   = 4'd8;
	localparam logic [3:0] OP_OUT    = 4'd9;

	// Sequencer jump conditions.
	localparam logic [3:0] C_NEXT  = 4'd0;
	localparam logic [3:0] C_JUMP  = 4'd1;
	localparam logic [3:0] C_IDLE  = 4'd2;
	localparam logic [3:0] C_PAD   = 4'd3;
	localparam logic [3:0] C_ZHI   = 4'd4;
	localparam logic [3:0] C_ZLO   = 4'd5;
	localparam logic [3:0] C_ROUND = 4'd6;
	localparam logic [3:0] C_RET   = 4'd7;
	localparam logic [3:0] C_OUT   = 4'd8;

	// Microprogram addresses.
	localparam int unsigned NUM_STEPS = 10;
	localparam logic [3:0] P_IDLE  = 4'd0;
	localparam logic [3:0] P_PAD   = 4'd1;
	localparam logic [3:0] P_ZHI   = 4'd2;
	localparam logic [3:0] P_ZLO   = 4'd3;
	localparam logic [3:0] P_LEN0  = 4'd4;
	localparam logic [3:0] P_LEN1  = 4'd5;
	localparam logic [3:0] P_CINIT = 4'd6;
	localparam logic [3:0] P_ROUND = 4'd7;
	localparam logic [3:0] P_CADD  = 4'd8;
	localparam logic [3:0] P_OUT   = 4'd9;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] cond;
		logic [3:0] target;
	} ctrl_t;

	typedef struct packed {
		logic acc;
		logic blk_full;
		logic eom;
		logic fill_hi;
		logic zidx_end;
		logic zidx_len;
		logic rnd_last;
		logic out_pend;
		logic pad_blk;
		logic fin_pend;
		logic out_done;
	} stat_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hEFCDAB89;
	localparam logic [31:0] IV_C = 32'h98BADCFE;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] K_TAB [64] = '{
		32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
		32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
		32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
		32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
		32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
		32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
		32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
		32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
		32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
		32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
		32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
		32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
		32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
		32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
		32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
		32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
	};

	localparam logic [4:0] ROT_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

endpackage

FILE: hw/rtl/md5_useq.sv
// Microprogram sequencer: step counter, control store and jump logic.
module md5_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  md5_pkg::stat_t stat,
	output md5_pkg::ctrl_t ctrl
);
	import md5_pkg::*;

	// Control store, one word per step.
	localparam ctrl_t UCODE [NUM_STEPS] = '{
		'{OP_ABSORB, C_IDLE,  P_IDLE},
		'{OP_PAD,    C_PAD,   P_IDLE},
		'{OP_ZHI,    C_ZHI,   P_CINIT},
		'{OP_ZLO,    C_ZLO,   P_LEN0},
		'{OP_LEN0,   C_NEXT,  P_IDLE},
		'{OP_LEN1,   C_JUMP,  P_CINIT},
		'{OP_CINIT,  C_NEXT,  P_IDLE},
		'{OP_ROUND,  C_ROUND, P_CADD},
		'{OP_CADD,   C_RET,   P_IDLE},
		'{OP_OUT,    C_OUT,   P_IDLE}
	};

	logic [3:0] pc_q;
	logic [3:0] pc_d;

	assign ctrl = UCODE[pc_q];

	always_comb begin
		pc_d = pc_q;
		case (ctrl.cond)
			C_NEXT:  pc_d = pc_q + 4'd1;
			C_JUMP:  pc_d = ctrl.target;
			C_IDLE: begin
				if (stat.acc && stat.blk_full) begin
					pc_d = P_CINIT;
				end else if (stat.acc && stat.eom) begin
					pc_d = P_PAD;
				end
			end
			C_PAD:   pc_d = stat.fill_hi ? P_ZHI : P_ZLO;
			C_ZHI:   pc_d = stat.zidx_end ? ctrl.target : pc_q;
			C_ZLO:   pc_d = stat.zidx_len ? ctrl.target : pc_q;
			C_ROUND: pc_d = stat.rnd_last ? ctrl.target : pc_q;
			C_OUT:   pc_d = stat.out_done ? ctrl.target : pc_q;
			C_RET: begin
				// A compression returns to whichever step asked for it.
				if (stat.out_pend) begin
					pc_d = P_OUT;
				end else if (stat.pad_blk) begin
					pc_d = P_ZLO;
				end else if (stat.fin_pend) begin
					pc_d = P_PAD;
				end else begin
					pc_d = P_IDLE;
				end
			end
			default: pc_d = P_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

FILE: hw/rtl/md5_dpath.sv
// Datapath: block word memory, byte packing, padding, MD5 round and digest output.
module md5_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  md5_pkg::ctrl_t ctrl,
	output md5_pkg::stat_t stat,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,
	input  logic           s_tuser,
	input  logic           s_tlast,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [31:0]    m_tdata,
	output logic [1:0]     m_tuser,
	output logic           m_tlast
);
	import md5_pkg::*;

	logic [31:0] blk_mem_q [16];
	logic [31:0] rd_data_q;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [31:0] wr_data;
	logic [3:0]  rd_addr;

	logic [31:0] asm_q;
	logic [5:0]  fill_q;
	logic [63:0] total_q;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic [4:0]  zidx_q;
	logic [1:0]  oidx_q;
	logic        fin_pend_q, pad_blk_q, out_pend_q;

	logic        acc, out_hs;
	logic [31:0] pad_word;
	logic [31:0] f_val, t_val, rot_val;
	logic [63:0] rot_dbl;
	logic [5:0]  rnd_nx;
	logic [3:0]  g_nx;
	logic [3:0]  rlo;

	assign s_tready = (ctrl.op == OP_ABSORB);
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = (ctrl.op == OP_OUT);
	assign out_hs   = m_tvalid && m_tready;
	assign m_tdata  = chain_q[oidx_q];
	assign m_tuser  = oidx_q;
	assign m_tlast  = (oidx_q == 2'd3);

	always_comb begin
		stat          = '0;
		stat.acc      = acc;
		stat.blk_full = acc && s_tuser && (fill_q == 6'd63);
		stat.eom      = s_tlast;
		stat.fill_hi  = (fill_q[5:3] == 3'd7);
		stat.zidx_end = zidx_q[4];
		stat.zidx_len = (zidx_q == 5'd14);
		stat.rnd_last = (rnd_q == 6'd63);
		stat.out_pend = out_pend_q;
		stat.pad_blk  = pad_blk_q;
		stat.fin_pend = fin_pend_q;
		stat.out_done = out_hs && m_tlast;
	end

	// Partial word with the pad mark after the bytes already packed.
	always_comb begin
		case (fill_q[1:0])
			2'd0:    pad_word = {24'd0, PAD_MARK};
			2'd1:    pad_word = {16'd0, PAD_MARK, asm_q[7:0]};
			2'd2:    pad_word = {8'd0, PAD_MARK, asm_q[15:0]};
			default: pad_word = {PAD_MARK, asm_q[23:0]};
		endcase
	end

	// Round function and the message word index of the following round.
	always_comb begin
		case (rnd_q[5:4])
			2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f_val = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
		t_val   = a_q + f_val + rd_data_q + K_TAB[rnd_q];
		rot_dbl = {t_val, t_val} << ROT_TAB[{rnd_q[5:4], rnd_q[1:0]}];
		rot_val = rot_dbl[63:32];

		rnd_nx = rnd_q + 6'd1;
		rlo    = rnd_nx[3:0];
		case (rnd_nx[5:4])
			2'd0:    g_nx = rlo;
			2'd1:    g_nx = 4'(rlo * 4'd5 + 4'd1);
			2'd2:    g_nx = 4'(rlo * 4'd3 + 4'd5);
			default: g_nx = 4'(rlo * 4'd7);
		endcase
	end

	// Write port and read address of the block memory.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q[5:2];
		wr_data = {s_tdata, asm_q[23:0]};
		rd_addr = 4'd0;
		case (ctrl.op)
			OP_ABSORB: wr_en = acc && s_tuser && (fill_q[1:0] == 2'd3);
			OP_PAD: begin
				wr_en   = 1'b1;
				wr_data = pad_word;
			end
			OP_ZHI: begin
				wr_en   = !zidx_q[4];
				wr_addr = zidx_q[3:0];
				wr_data = '0;
			end
			OP_ZLO: begin
				wr_en   = (zidx_q != 5'd14);
				wr_addr = zidx_q[3:0];
				wr_data = '0;
			end
			OP_LEN0: begin
				wr_en   = 1'b1;
				wr_addr = 4'd14;
				wr_data = total_q[31:0];
			end
			OP_LEN1: begin
				wr_en   = 1'b1;
				wr_addr = 4'd15;
				wr_data = total_q[63:32];
			end
			OP_ROUND: rd_addr = g_nx;
			default:  rd_addr = 4'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= blk_mem_q[rd_addr];
	end

	// Working registers of the compression; no reset needed.
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_ABSORB && acc && s_tuser) begin
			asm_q[8*fill_q[1:0] +: 8] <= s_tdata;
		end
		if (ctrl.op == OP_CINIT) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (ctrl.op == OP_ROUND) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			total_q    <= '0;
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
			rnd_q      <= '0;
			zidx_q     <= '0;
			oidx_q     <= '0;
			fin_pend_q <= 1'b0;
			pad_blk_q  <= 1'b0;
			out_pend_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_ABSORB: begin
					if (acc) begin
						fin_pend_q <= s_tlast;
						if (s_tuser) begin
							fill_q <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								total_q <= total_q + 64'd512;
							end
						end
					end
				end
				OP_PAD: begin
					total_q    <= total_q + 64'({fill_q, 3'b000});
					zidx_q     <= {1'b0, fill_q[5:2]} + 5'd1;
					fin_pend_q <= 1'b0;
					pad_blk_q  <= (fill_q[5:3] == 3'd7);
				end
				OP_ZHI, OP_ZLO: begin
					if (wr_en) begin
						zidx_q <= zidx_q + 5'd1;
					end
				end
				OP_LEN1:  out_pend_q <= 1'b1;
				OP_CINIT: rnd_q <= '0;
				OP_ROUND: rnd_q <= rnd_nx;
				OP_CADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					if (!out_pend_q && pad_blk_q) begin
						pad_blk_q <= 1'b0;
						zidx_q    <= '0;
					end
				end
				OP_OUT: begin
					if (out_hs) begin
						oidx_q <= oidx_q + 2'd1;
						if (m_tlast) begin
							fill_q     <= '0;
							total_q    <= '0;
							chain_q[0] <= IV_A;
							chain_q[1] <= IV_B;
							chain_q[2] <= IV_C;
							chain_q[3] <= IV_D;
							out_pend_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/md5_message_digest.sv
// Top level of the MD5 message digest block.
//
// Input stream (s_*): one item per message byte. s_tdata carries the byte,
// s_tuser says whether the byte is part of the message, and s_tlast marks
// the final item of a message. An item with s_tlast and s_tuser low closes
// the message without adding a byte, which also gives the empty digest.
// Output stream (m_*): four items per message, chaining words A, B, C, D.
// m_tuser is the word index and m_tlast is high on word D.
//
// Timing: while a block fills, one byte is taken each cycle. The item that
// completes a 64-byte block is followed by a compression (load, 64 rounds
// at one round per cycle through the single round unit, add), during which
// s_tready is low. At the end of a message the block writes the pad mark,
// the zero fill and the bit length, in an extra block when the length
// spills, runs one or two compressions, then offers the digest words;
// they leave at one per cycle when the receiver is ready. A stalled
// receiver holds the current word and the block takes no new input until
// word D is taken. Reset clears the byte count and bit length and loads
// the initial chaining words; the block memory holds no reset value and
// is always rewritten before it is read.
module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] message_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [1:0]  m_tuser,   // [1:0] word_index
	output logic        m_tlast    // last_word
);
	import md5_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// The sequencer steps through the control store; every step drives
	// one datapath operation and picks the next step from the status.
	md5_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// The datapath owns both stream ports, the block memory and the
	// chaining words.
	md5_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: hw/rtl/md5_checker.sv
// Port-level checks of the MD5 digest block, bound to its top level.
module md5_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled digest word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled digest word changed");

	// Input is never taken while a digest is being delivered.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during digest output");

	// Digest words follow in order without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tuser == $past(m_tuser) + 2'd1))
		else $error("digest word out of order");

	// The last mark sits on word D alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
		else $error("last mark on wrong word");

	// After word D the block is ready for the next message at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("block not ready after digest");

endmodule

bind md5_message_digest md5_checker u_md5_checker (.*);

FILE: test/md5_digest_checker.sv
// Scoreboard for the MD5 digest block: predicts each digest from the input items and compares.
module md5_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	output int unsigned words_due,
	output int unsigned failures
);

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned LEN_OFFSET  = 56;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;

	localparam logic [31:0] SINE_TAB [64] = '{
		32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
		32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
		32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
		32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
		32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
		32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
		32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
		32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
		32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
		32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
		32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
		32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
		32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
		32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
		32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
		32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
	};

	localparam int unsigned SHIFT_TAB [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_word_t;

	logic [7:0]   msg_buf [64];
	int unsigned  msg_fill;
	logic [63:0]  msg_bits;
	logic [31:0]  chain [4];
	digest_word_t digest_q [$];

	function automatic void chain_restart();
		msg_fill = 0;
		msg_bits = '0;
		chain[0] = INIT_A;
		chain[1] = INIT_B;
		chain[2] = INIT_C;
		chain[3] = INIT_D;
	endfunction

	// One 64-round compression of msg_buf into the chaining words.
	function automatic void md5_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int unsigned g, s, phase;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int r = 0; r < 16; r++)
			w[r] = {msg_buf[4*r+3], msg_buf[4*r+2], msg_buf[4*r+1], msg_buf[4*r]};
		for (int r = 0; r < 64; r++) begin
			phase = r / 16;
			case (phase)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			t = a + f + w[g] + SINE_TAB[r];
			s = SHIFT_TAB[phase * 4 + r % 4];
			a = d;
			d = c;
			c = b;
			b = b + ((t << s) | (t >> (32 - s)));
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int unsigned pos;
		digest_word_t want;
		if (!arst_n) begin
			chain_restart();
			digest_q.delete();
			failures = 0;
			words_due <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					msg_buf[msg_fill] = s_tdata;
					msg_fill++;
					// A full block is folded in at once.
					if (msg_fill == BLOCK_BYTES) begin
						md5_compress();
						msg_bits += 64'd512;
						msg_fill = 0;
					end
				end
				if (s_tlast) begin
					// Pad with the marker byte, zeros and the bit length; a tail of
					// 56 bytes or more spills the length into an extra block.
					msg_bits += 64'(msg_fill) * 64'd8;
					pos = msg_fill;
					msg_buf[pos] = PAD_BYTE;
					pos++;
					if (pos > LEN_OFFSET) begin
						while (pos < BLOCK_BYTES) begin
							msg_buf[pos] = 8'h00;
							pos++;
						end
						md5_compress();
						pos = 0;
					end
					while (pos < LEN_OFFSET) begin
						msg_buf[pos] = 8'h00;
						pos++;
					end
					for (int k = 0; k < 8; k++)
						msg_buf[LEN_OFFSET + k] = msg_bits[8*k +: 8];
					md5_compress();
					for (int k = 0; k < 4; k++) begin
						want.word  = chain[k];
						want.index = 2'(k);
						want.last  = (k == 3);
						digest_q.push_back(want);
					end
					chain_restart();
				end
			end
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest item: digest_word %h word_index %0d last_word %0d",
						m_tdata, m_tuser, m_tlast);
					failures++;
				end else begin
					want = digest_q.pop_front();
					if (m_tdata !== want.word) begin
						$error("digest_word: expected %h, got %h", want.word, m_tdata);
						failures++;
					end
					if (m_tuser !== want.index) begin
						$error("word_index: expected %0d, got %0d", want.index, m_tuser);
						failures++;
					end
					if (m_tlast !== want.last) begin
						$error("last_word: expected %0d, got %0d", want.last, m_tlast);
						failures++;
					end
				end
			end
			words_due <= digest_q.size();
		end
	end

endmodule

FILE: test/tb_md5_message_digest.sv
// Testbench top for the MD5 digest block: stimulus, receiver stalls, timeout and verdict.
module tb_md5_message_digest;

	localparam int unsigned RANDOM_ITEMS = 310;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned HOLD_CYCLES  = 400;
	// Two compressions plus padding, with margin, once nothing is expected.
	localparam int unsigned DRAIN_CYCLES = 200;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tuser  = 1'b0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int unsigned words_due;
	int unsigned failures;

	int unsigned items_sent    = 0;
	int unsigned bytes_sent    = 0;
	int unsigned messages_sent = 0;
	int unsigned noise_sent    = 0;
	int unsigned msg_len       = 0;
	int unsigned burst_left    = 0;
	int unsigned cycles        = 0;
	int unsigned rx_mode       = 0;
	int unsigned rx_left       = 0;
	bit          seen_fit_tail    = 1'b0;
	bit          seen_spill_tail  = 1'b0;
	bit          seen_multi_block = 1'b0;
	bit          hold_req         = 1'b0;
	bit          hold_used        = 1'b0;

	always #4 clk = ~clk;

	md5_message_digest i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	md5_digest_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.words_due (words_due),
		.failures  (failures)
	);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** md5_message_digest: FAILED **");
			$finish;
		end
	end

	// Receiver: switches among stall patterns after runs of random length, and on
	// request holds off for a long stretch so the block backs up into its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(16, 96);
				end
				rx_left--;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (rx_left % 12 == 0);
				endcase
			end
		end
	end

	// Offers one item and returns after the edge at which it was taken. The
	// sender runs in bursts; a gap between bursts drops tvalid for a while.
	task automatic offer(input logic [7:0] data, input logic present, input logic eom);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		items_sent++;
		if (!present && !eom)
			noise_sent++;
		if (present) begin
			bytes_sent++;
			msg_len++;
		end
		if (eom) begin
			messages_sent++;
			// Tails of 56 bytes or more need an extra padding block.
			if (msg_len % 64 >= 56)
				seen_spill_tail = 1'b1;
			else
				seen_fit_tail = 1'b1;
			if (msg_len >= 64)
				seen_multi_block = 1'b1;
			msg_len = 0;
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// A message of len random bytes with an occasional ignored item among them.
	// The end mark either rides on the last byte or comes as an empty tail.
	task automatic send_message(input int unsigned len, input bit empty_tail);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			offer(8'($urandom_range(0, 255)), 1'b1, !empty_tail && i == len - 1);
		end
		if (empty_tail || len == 0)
			offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Stops offering until every predicted digest word has been taken. The
	// count is registered, so it is first looked at after the next edge.
	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned sel;
		int unsigned len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, single bytes at both extremes, "abc",
		// an empty tail after bytes, and ignored items inside a message.
		offer(8'h00, 1'b0, 1'b1);
		offer(8'h00, 1'b1, 1'b1);
		offer(8'hFF, 1'b1, 1'b1);
		offer(8'h61, 1'b1, 1'b0);
		offer(8'h62, 1'b1, 1'b0);
		offer(8'h63, 1'b1, 1'b1);
		offer(8'h80, 1'b1, 1'b0);
		offer(8'h7F, 1'b1, 1'b0);
		offer(8'hFF, 1'b0, 1'b1);
		offer(8'hA5, 1'b0, 1'b0);
		offer(8'h5A, 1'b0, 1'b0);
		offer(8'h55, 1'b1, 1'b0);
		offer(8'hAA, 1'b1, 1'b0);
		offer(8'h01, 1'b1, 1'b0);
		offer(8'hFE, 1'b1, 1'b1);
		wait_results();

		// Random messages, weighted toward short ones and lengths near the
		// 56- and 64-byte boundaries, until the budget and all tail shapes are met.
		while (items_sent < RANDOM_ITEMS || !seen_fit_tail || !seen_spill_tail ||
				!seen_multi_block) begin
			if (!hold_used && messages_sent >= 8) begin
				hold_used = 1'b1;
				hold_req  = 1'b1;
				send_message($urandom_range(1, 8), 1'b0);
			end
			sel = $urandom_range(0, 99);
			if (sel < 40)
				len = $urandom_range(0, 8);
			else if (sel < 75)
				len = $urandom_range(52, 66);
			else if (sel < 90)
				len = $urandom_range(9, 51);
			else
				len = $urandom_range(110, 135);
			// Once every tail shape has been seen, the last message only tops up
			// the item budget.
			if (seen_fit_tail && seen_spill_tail && seen_multi_block &&
					items_sent < RANDOM_ITEMS && len > RANDOM_ITEMS - items_sent)
				len = RANDOM_ITEMS - items_sent;
			send_message(len, $urandom_range(0, 3) == 0);
		end

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d messages, %0d message bytes and %0d ignored items,",
			messages_sent, bytes_sent, noise_sent);
		$display("with empty tails, extra padding blocks, multi-block messages and a long output stall.");
		if (failures == 0 && words_due == 0)
			$display("** md5_message_digest: PASSED **");
		else
			$display("** md5_message_digest: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/md5_pkg.sv
hw/rtl/md5_useq.sv
hw/rtl/md5_dpath.sv
hw/rtl/md5_message_digest.sv
hw/rtl/md5_checker.sv
test/md5_digest_checker.sv
test/tb_md5_message_digest.sv
